// ===== src/sesd_pkg.sv =====
package sesd_pkg;

  // result field widths, fixed by the output format
  localparam int unsigned MAG_W       = 17;
  localparam int unsigned CANDS_W     = 4;
  localparam int unsigned DUR_W       = 32;
  localparam int unsigned OUT_W       = MAG_W + 4 + CANDS_W + DUR_W;
  localparam int unsigned OUT_TDATA_W = ((OUT_W + 7) / 8) * 8;

  // configuration port
  localparam int unsigned CFG_W      = 16;
  localparam int unsigned REQ_W      = 4;
  localparam int unsigned APB_ADDR_W = 5;
  localparam int unsigned APB_DATA_W = 32;
  localparam int unsigned REG_IDX_W  = 3;

  // entries in the front to back queue
  localparam int unsigned QDEPTH = 2;

  localparam logic [CFG_W-1:0] PEAK_THRESHOLD_RST   = 16'd2376;
  localparam logic [CFG_W-1:0] MIN_PEAK_SPACING_RST = 16'd100;
  localparam logic [CFG_W-1:0] CANDIDATE_WINDOW_RST = 16'd700;
  localparam logic [CFG_W-1:0] MAX_ACTIVE_GAP_RST   = 16'd650;
  localparam logic [REQ_W-1:0] REQUIRED_PEAKS_RST   = 4'd2;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_PEAK_THRESHOLD   = 3'd0,
    REG_MIN_PEAK_SPACING = 3'd1,
    REG_CANDIDATE_WINDOW = 3'd2,
    REG_MAX_ACTIVE_GAP   = 3'd3,
    REG_REQUIRED_PEAKS   = 3'd4
  } reg_idx_e;

  typedef struct packed {
    logic [CFG_W-1:0] peak_threshold;
    logic [CFG_W-1:0] min_peak_spacing;
    logic [CFG_W-1:0] candidate_window;
    logic [CFG_W-1:0] max_active_gap;
    logic [REQ_W-1:0] required_peaks;
  } cfg_t;

  // first member lands in the top bits, so the magnitude ends up lowest
  typedef struct packed {
    logic [DUR_W-1:0]   active_duration;
    logic [CANDS_W-1:0] candidates_now;
    logic               session_on;
    logic               session_ended;
    logic               session_began;
    logic               peak_seen;
    logic [MAG_W-1:0]   delta_magnitude;
  } result_t;

  typedef enum logic [1:0] {
    F_IDLE,
    F_SQUARE,
    F_SUM,
    F_PUSH
  } front_state_e;

  typedef enum logic [1:0] {
    B_IDLE,
    B_ROOT,
    B_DONE
  } back_state_e;

endpackage

// ===== src/shake_session_detector_top.sv =====
// channel   dir  handshake                        payload
// s_axis    in   s_axis_tvalid_i/s_axis_tready_o  accel_x, accel_y, accel_z, time_ms
// m_axis    out  m_axis_tvalid_o/m_axis_tready_i  delta_magnitude .. active_duration
// apb       in   psel/penable/pready              five 32-bit registers at 4*index
//
// the front accepts a beat, squares, sums and hands it to the queue before it takes the next
// one, and the hand-off waits while the queue is full; the back runs the square root unit,
// which resolves one root bit a cycle, before the result goes to the output register
// a priming sample skips the root
// reset clears the session state and loads register defaults; no clearing pass
// a two-entry queue lets the front keep accepting while the root runs, and the
// output register holds a result beat until the sink takes it
module shake_session_detector_top #(
  parameter int unsigned SAMPLE_WIDTH = 16,
  parameter int unsigned TIME_WIDTH   = 32
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  // stream in
  input  logic                                  s_axis_tvalid_i,
  output logic                                  s_axis_tready_o,
  // accel_x, accel_y, accel_z, time_ms, zero pad
  input  logic [((3*SAMPLE_WIDTH+TIME_WIDTH+7)/8)*8-1:0] s_axis_tdata_i,
  // stream out
  output logic                                  m_axis_tvalid_o,
  input  logic                                  m_axis_tready_i,
  // delta_magnitude, peak_seen, session_began, session_ended, session_on,
  // candidates_now, active_duration, zero pad
  output logic [sesd_pkg::OUT_TDATA_W-1:0]      m_axis_tdata_o,
  // register port
  input  logic                                  psel,
  input  logic                                  penable,
  input  logic                                  pwrite,
  input  logic [sesd_pkg::APB_ADDR_W-1:0]       paddr,
  input  logic [sesd_pkg::APB_DATA_W-1:0]       pwdata,
  output logic [sesd_pkg::APB_DATA_W-1:0]       prdata,
  output logic                                  pready
);
  import sesd_pkg::*;

  localparam int unsigned SW      = SAMPLE_WIDTH;
  localparam int unsigned TW      = TIME_WIDTH;
  localparam int unsigned ENTRY_W = 2 * SW + 3 + TW;

  cfg_t     cfg_q;
  reg_idx_e reg_idx;
  logic     cfg_wr;

  logic               q_push, q_pop, q_full, q_empty;
  logic [ENTRY_W-1:0] q_wdata, q_rdata;
  result_t            res;

  // register file
  assign pready  = 1'b1;
  assign reg_idx = reg_idx_e'(paddr[APB_ADDR_W-1:2]);
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.peak_threshold   <= PEAK_THRESHOLD_RST;
      cfg_q.min_peak_spacing <= MIN_PEAK_SPACING_RST;
      cfg_q.candidate_window <= CANDIDATE_WINDOW_RST;
      cfg_q.max_active_gap   <= MAX_ACTIVE_GAP_RST;
      cfg_q.required_peaks   <= REQUIRED_PEAKS_RST;
    end else if (cfg_wr) begin
      case (reg_idx)
        REG_PEAK_THRESHOLD:   cfg_q.peak_threshold   <= pwdata[CFG_W-1:0];
        REG_MIN_PEAK_SPACING: cfg_q.min_peak_spacing <= pwdata[CFG_W-1:0];
        REG_CANDIDATE_WINDOW: cfg_q.candidate_window <= pwdata[CFG_W-1:0];
        REG_MAX_ACTIVE_GAP:   cfg_q.max_active_gap   <= pwdata[CFG_W-1:0];
        REG_REQUIRED_PEAKS:   cfg_q.required_peaks   <= pwdata[REQ_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_PEAK_THRESHOLD:   prdata = APB_DATA_W'(cfg_q.peak_threshold);
      REG_MIN_PEAK_SPACING: prdata = APB_DATA_W'(cfg_q.min_peak_spacing);
      REG_CANDIDATE_WINDOW: prdata = APB_DATA_W'(cfg_q.candidate_window);
      REG_MAX_ACTIVE_GAP:   prdata = APB_DATA_W'(cfg_q.max_active_gap);
      REG_REQUIRED_PEAKS:   prdata = APB_DATA_W'(cfg_q.required_peaks);
      default:              prdata = '0;
    endcase
  end

  // front: previous sample, differences and squared sum
  sesd_front #(
    .SAMPLE_WIDTH(SW),
    .TIME_WIDTH  (TW)
  ) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(s_axis_tvalid_i),
    .in_ready_o(s_axis_tready_o),
    .accel_x_i (s_axis_tdata_i[SW-1:0]),
    .accel_y_i (s_axis_tdata_i[2*SW-1:SW]),
    .accel_z_i (s_axis_tdata_i[3*SW-1:2*SW]),
    .time_ms_i (s_axis_tdata_i[3*SW+TW-1:3*SW]),
    .q_full_i  (q_full),
    .q_push_o  (q_push),
    .q_data_o  (q_wdata)
  );

  // prime flag, squared sum and timestamp waiting for the back
  sesd_queue #(
    .W(ENTRY_W)
  ) u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (q_push),
    .data_i (q_wdata),
    .full_o (q_full),
    .pop_i  (q_pop),
    .empty_o(q_empty),
    .data_o (q_rdata)
  );

  // back: square root, peak and session tracking, output register
  sesd_back #(
    .SAMPLE_WIDTH(SW),
    .TIME_WIDTH  (TW)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .q_empty_i  (q_empty),
    .q_data_i   (q_rdata),
    .q_pop_o    (q_pop),
    .out_valid_o(m_axis_tvalid_o),
    .out_ready_i(m_axis_tready_i),
    .out_data_o (res)
  );

  assign m_axis_tdata_o = {{(OUT_TDATA_W - OUT_W){1'b0}}, res};

endmodule

// ===== src/sesd_queue.sv =====
module sesd_queue #(
  parameter int unsigned W = 8
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         push_i,
  input  logic [W-1:0] data_i,
  output logic         full_o,
  input  logic         pop_i,
  output logic         empty_o,
  output logic [W-1:0] data_o
);
  import sesd_pkg::*;

  localparam int unsigned PTR_W = $clog2(QDEPTH);

  logic [W-1:0]     mem_q [QDEPTH];
  logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [PTR_W:0]   cnt_q;

  assign full_o  = (cnt_q == (PTR_W + 1)'(QDEPTH));
  assign empty_o = (cnt_q == '0);
  assign data_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

// ===== src/sesd_front.sv =====
module sesd_front #(
  parameter int unsigned SAMPLE_WIDTH = 16,
  parameter int unsigned TIME_WIDTH   = 32
) (
  input  logic                                        clk_i,
  input  logic                                        rst_ni,
  input  logic                                        in_valid_i,
  output logic                                        in_ready_o,
  input  logic [SAMPLE_WIDTH-1:0]                     accel_x_i,
  input  logic [SAMPLE_WIDTH-1:0]                     accel_y_i,
  input  logic [SAMPLE_WIDTH-1:0]                     accel_z_i,
  input  logic [TIME_WIDTH-1:0]                       time_ms_i,
  input  logic                                        q_full_i,
  output logic                                        q_push_o,
  output logic [2*SAMPLE_WIDTH+2+TIME_WIDTH:0]        q_data_o
);
  import sesd_pkg::*;

  localparam int unsigned SW    = SAMPLE_WIDTH;
  localparam int unsigned SUM_W = 2 * SW + 2;

  front_state_e state_q, state_d;

  logic                  primed_q;
  logic [SW-1:0]         last_x_q, last_y_q, last_z_q;
  logic                  prime_q;
  logic [TIME_WIDTH-1:0] now_q;
  logic [SW:0]           adx_q, ady_q, adz_q;
  logic [SUM_W-1:0]      sqx_q, sqy_q, sqz_q, sum_q;
  logic                  accept;
  logic signed [SW:0]    dx, dy, dz;
  logic [SW:0]           adx, ady, adz;
  logic [SUM_W-1:0]      sqx, sqy, sqz;

  assign accept = in_valid_i && in_ready_o;

  // differences against the previous sample, one bit wider, then magnitude
  assign dx  = $signed({accel_x_i[SW-1], accel_x_i}) - $signed({last_x_q[SW-1], last_x_q});
  assign dy  = $signed({accel_y_i[SW-1], accel_y_i}) - $signed({last_y_q[SW-1], last_y_q});
  assign dz  = $signed({accel_z_i[SW-1], accel_z_i}) - $signed({last_z_q[SW-1], last_z_q});
  assign adx = dx[SW] ? (~dx + 1'b1) : dx;
  assign ady = dy[SW] ? (~dy + 1'b1) : dy;
  assign adz = dz[SW] ? (~dz + 1'b1) : dz;

  assign sqx = adx_q * adx_q;
  assign sqy = ady_q * ady_q;
  assign sqz = adz_q * adz_q;

  assign q_data_o = {prime_q, sum_q, now_q};

  always_comb begin
    state_d    = state_q;
    in_ready_o = 1'b0;
    q_push_o   = 1'b0;
    case (state_q)
      F_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          state_d = F_SQUARE;
        end
      end
      F_SQUARE: state_d = F_SUM;
      F_SUM:    state_d = F_PUSH;
      F_PUSH: begin
        q_push_o = !q_full_i;
        if (!q_full_i) begin
          state_d = F_IDLE;
        end
      end
      default: state_d = F_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= F_IDLE;
      primed_q <= 1'b0;
      last_x_q <= '0;
      last_y_q <= '0;
      last_z_q <= '0;
    end else begin
      state_q <= state_d;
      if (accept) begin
        primed_q <= 1'b1;
        last_x_q <= accel_x_i;
        last_y_q <= accel_y_i;
        last_z_q <= accel_z_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      prime_q <= !primed_q;
      now_q   <= time_ms_i;
      adx_q   <= adx;
      ady_q   <= ady;
      adz_q   <= adz;
    end
    if (state_q == F_SQUARE) begin
      sqx_q <= sqx;
      sqy_q <= sqy;
      sqz_q <= sqz;
    end
    if (state_q == F_SUM) begin
      sum_q <= sqx_q + sqy_q + sqz_q;
    end
  end

endmodule

// ===== src/sesd_back.sv =====
module sesd_back #(
  parameter int unsigned SAMPLE_WIDTH = 16,
  parameter int unsigned TIME_WIDTH   = 32
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  sesd_pkg::cfg_t                       cfg_i,
  input  logic                                 q_empty_i,
  input  logic [2*SAMPLE_WIDTH+2+TIME_WIDTH:0] q_data_i,
  output logic                                 q_pop_o,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output sesd_pkg::result_t                    out_data_o
);
  import sesd_pkg::*;

  localparam int unsigned TW     = TIME_WIDTH;
  localparam int unsigned SUM_W  = 2 * SAMPLE_WIDTH + 2;
  localparam int unsigned ITER_N = SUM_W / 2;
  localparam int unsigned ITER_W = $clog2(ITER_N);
  localparam int unsigned CMP_W  = (SUM_W > 32) ? SUM_W : 32;

  back_state_e state_q, state_d;

  // item being worked on
  logic              prime_q;
  logic [SUM_W-1:0]  sum_q, rem_q, root_q, bit_q;
  logic [ITER_W-1:0] iter_q;
  logic [TW-1:0]     now_q, dpeak_q, dsess_q, dcand_q;
  logic [31:0]       thr2_q;

  // session state
  logic               in_session_q;
  logic [CANDS_W-1:0] cand_cnt_q;
  logic [TW-1:0]      last_peak_q, sess_start_q, cand_start_q;

  logic    out_valid_q;
  result_t out_q;

  logic              pop, fire;
  logic              q_prime;
  logic [SUM_W-1:0]  q_sum;
  logic [TW-1:0]     q_now;
  logic [SUM_W-1:0]  trial;

  // decision signals
  logic               ended, ins1, spacing_ok, first_cand, peak;
  logic [CANDS_W-1:0] cc1, cc2, cc3;
  logic               in_session_d;
  logic [CANDS_W-1:0] cand_cnt_d;
  logic               upd_peak, upd_cand_start, upd_sess_start;
  result_t            res;

  assign {q_prime, q_sum, q_now} = q_data_i;
  assign trial       = root_q + bit_q;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  always_comb begin
    state_d = state_q;
    pop     = 1'b0;
    fire    = 1'b0;
    case (state_q)
      B_IDLE: begin
        pop = !q_empty_i;
        if (!q_empty_i) begin
          state_d = q_prime ? B_DONE : B_ROOT;
        end
      end
      B_ROOT: begin
        if (iter_q == '0) begin
          state_d = B_DONE;
        end
      end
      B_DONE: begin
        fire = !out_valid_q || out_ready_i;
        if (fire) begin
          state_d = B_IDLE;
        end
      end
      default: state_d = B_IDLE;
    endcase
  end

  assign q_pop_o = pop;

  // peak and session decision, on time differences taken when the item came in
  always_comb begin
    ended = in_session_q && (dpeak_q > TW'(cfg_i.max_active_gap));
    ins1  = in_session_q && !ended;
    cc1   = ended ? '0 : cand_cnt_q;
    if (!ins1 && (cc1 != '0) && (dcand_q > TW'(cfg_i.candidate_window))) begin
      cc2 = '0;
    end else begin
      cc2 = cc1;
    end
    spacing_ok = (ins1 || (cc2 != '0)) && (dpeak_q >= TW'(cfg_i.min_peak_spacing));
    first_cand = !ins1 && (cc2 == '0);
    peak       = (CMP_W'(sum_q) >= CMP_W'(thr2_q)) && (first_cand || spacing_ok);
    cc3        = cc2 + 1'b1;

    res                 = '0;
    res.delta_magnitude = root_q[MAG_W-1:0];
    res.session_ended   = ended;
    if (in_session_q) begin
      res.active_duration[TW-1:0] = dsess_q;
    end

    in_session_d   = ins1;
    cand_cnt_d     = cc2;
    upd_peak       = 1'b0;
    upd_cand_start = 1'b0;
    upd_sess_start = 1'b0;

    if (!peak) begin
      res.candidates_now = cc2;
      res.session_on     = ins1;
    end else begin
      res.peak_seen = 1'b1;
      upd_peak      = 1'b1;
      if (ins1) begin
        res.session_on = 1'b1;
      end else begin
        upd_cand_start     = (cc2 == '0);
        res.candidates_now = cc3;
        cand_cnt_d         = cc3;
        if (cc3 >= cfg_i.required_peaks) begin
          in_session_d       = 1'b1;
          upd_sess_start     = 1'b1;
          cand_cnt_d         = '0;
          res.candidates_now = '0;
          res.session_began  = 1'b1;
          res.session_on     = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= B_IDLE;
      out_valid_q  <= 1'b0;
      in_session_q <= 1'b0;
      cand_cnt_q   <= '0;
      last_peak_q  <= '0;
      sess_start_q <= '0;
      cand_start_q <= '0;
    end else begin
      state_q <= state_d;
      if (fire) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (fire && !prime_q) begin
        in_session_q <= in_session_d;
        cand_cnt_q   <= cand_cnt_d;
        if (upd_peak) begin
          last_peak_q <= now_q;
        end
        if (upd_cand_start) begin
          cand_start_q <= now_q;
        end
        if (upd_sess_start) begin
          sess_start_q <= now_q;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      prime_q <= q_prime;
      sum_q   <= q_sum;
      rem_q   <= q_sum;
      root_q  <= '0;
      bit_q   <= SUM_W'(1) << (SUM_W - 2);
      iter_q  <= ITER_W'(ITER_N - 1);
      now_q   <= q_now;
      dpeak_q <= q_now - last_peak_q;
      dsess_q <= q_now - sess_start_q;
      dcand_q <= q_now - cand_start_q;
      thr2_q  <= cfg_i.peak_threshold * cfg_i.peak_threshold;
    end else if (state_q == B_ROOT) begin
      // one root bit per cycle
      if (rem_q >= trial) begin
        rem_q  <= rem_q - trial;
        root_q <= (root_q >> 1) + bit_q;
      end else begin
        root_q <= root_q >> 1;
      end
      bit_q  <= bit_q >> 2;
      iter_q <= iter_q - 1'b1;
    end
    if (fire) begin
      out_q <= prime_q ? result_t'('0) : res;
    end
  end

endmodule

// ===== src/sesd_checker.sv =====
module sesd_checker (
  input logic                               clk_i,
  input logic                               rst_ni,
  input logic                               m_axis_tvalid_o,
  input logic                               m_axis_tready_i,
  input logic [sesd_pkg::OUT_TDATA_W-1:0]   m_axis_tdata_o
);
  import sesd_pkg::*;

  result_t res;
  assign res = m_axis_tdata_o[OUT_W-1:0];

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o))
    else $error("result beat changed while stalled");

  // a session start is reported as on with the candidate count cleared
  a_began_on: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && res.session_began |-> res.session_on && (res.candidates_now == '0))
    else $error("session start without session on or with candidates left");

  // a session only starts on a counted peak
  a_began_peak: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && res.session_began |-> res.peak_seen)
    else $error("session start without a peak");

  // an end with no restart leaves the session off
  a_ended_off: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && res.session_ended && !res.session_began |-> !res.session_on)
    else $error("session still on after it ended");

endmodule

bind shake_session_detector_top sesd_checker u_sesd_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .m_axis_tvalid_o(m_axis_tvalid_o),
  .m_axis_tready_i(m_axis_tready_i),
  .m_axis_tdata_o (m_axis_tdata_o)
);
